// ----- src/lpr_pkg.sv -----
// shared types and constants for the lru page replacement block
`timescale 1ns / 1ps

package lpr_pkg;

  // fixed widths of the channel fields
  localparam int unsigned PAGE_FIELD_W = 16;
  localparam int unsigned CFG_W        = 5;
  localparam int unsigned COUNT_W      = 32;

  // frame limit after reset
  localparam logic [CFG_W-1:0] LIMIT_RESET = 5'd16;

  // saturation value of the request and fault counts
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // result outcome codes
  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2,
    OUT_ZERO  = 2'd3
  } outcome_e;

endpackage

// ----- src/lpr_if.sv -----
// valid/ready channel interfaces for page requests, results and configuration
`timescale 1ns / 1ps

interface lpr_page_if;
  logic                                valid;
  logic                                ready;
  logic [lpr_pkg::PAGE_FIELD_W-1:0]    page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lpr_result_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          outcome;
  logic [lpr_pkg::PAGE_FIELD_W-1:0]    evicted_page;
  logic [lpr_pkg::COUNT_W-1:0]         request_count;
  logic [lpr_pkg::COUNT_W-1:0]         fault_count;

  modport source (output valid, output outcome, output evicted_page,
                  output request_count, output fault_count, input ready);
  modport sink   (input valid, input outcome, input evicted_page,
                  input request_count, input fault_count, output ready);
endinterface

interface lpr_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lpr_pkg::CFG_W-1:0]           frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink   (input valid, input frames_in_use, output ready);
endinterface

// ----- src/lpr_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module lpr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/lru_page_replacement.sv -----
// lru page replacement table: recency-ordered page list in a ram, walked per request
//
//  channel   | dir | beat carries                                   | accepted when
//  ----------+-----+------------------------------------------------+----------------------
//  page_in   | in  | page_number                                    | valid && ready
//  res_out   | out | outcome, evicted_page, request_count, fault_cnt | valid && ready
//  cfg_in    | in  | frames_in_use                                  | valid && ready
//
//  one request at a time; the ram holds slot 0 as least recent, slot filled-1 as most recent
//  page zero: no ram walk; hit at slot p: scan to p, shift the slots above p down, page on top
//  fill: scan all, write slot filled; eviction: scan all, shift slots 1.. down, page on top
//  reset clears fill count and counts and sets the limit to 16; no ram clearing pass is needed
//  a finished result waits in the output register while the next request is taken
`timescale 1ns / 1ps

module lru_page_replacement #(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lpr_page_if.sink     page_in,
  lpr_result_if.source res_out,
  lpr_cfg_if.sink      cfg_in
);

  localparam int unsigned IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned FILL_W = $clog2(FRAMES + 1);
  localparam int unsigned LIM_W  = (FILL_W > lpr_pkg::CFG_W) ? FILL_W : lpr_pkg::CFG_W;
  localparam int unsigned CNT_W  = lpr_pkg::COUNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MISS,
    ST_SHIFT,
    ST_FINISH
  } state_e;

  state_e                        state_q;
  logic [PAGE_BITS-1:0]          page_q;
  logic [PAGE_BITS-1:0]          first_q;
  logic [PAGE_BITS-1:0]          evict_q;
  logic [IDX_W-1:0]              idx_q;
  logic [FILL_W-1:0]             filled_q;
  logic [lpr_pkg::COUNT_W-1:0]   req_q;
  logic [lpr_pkg::COUNT_W-1:0]   fault_q;
  logic [lpr_pkg::CFG_W-1:0]     limit_cfg_q;
  lpr_pkg::outcome_e             outcome_q;

  logic                          out_valid_q;
  logic [1:0]                    out_outcome_q;
  logic [lpr_pkg::PAGE_FIELD_W-1:0] out_evict_q;
  logic [lpr_pkg::COUNT_W-1:0]   out_req_q;
  logic [lpr_pkg::COUNT_W-1:0]   out_fault_q;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [PAGE_BITS-1:0]          ram_wdata;
  logic [IDX_W-1:0]              ram_raddr;
  logic [PAGE_BITS-1:0]          ram_rdata;

  logic [31:0]                   page_wide;
  logic [PAGE_BITS-1:0]          page_in_masked;
  logic [31:0]                   evict_wide;
  logic [LIM_W-1:0]              cfg_ext;
  logic [LIM_W-1:0]              limit;
  logic [LIM_W-1:0]              fill_ext;
  logic [FILL_W-1:0]             fill_m1;
  logic [IDX_W-1:0]              last_idx;
  logic                          has_free;
  logic                          in_beat;
  logic                          out_free;

  // field width adaption
  assign page_wide      = 32'(page_in.page_number);
  assign page_in_masked = page_wide[PAGE_BITS-1:0];
  assign evict_wide     = 32'(evict_q);

  // effective frame limit, clamped to 1..FRAMES
  assign cfg_ext  = LIM_W'(limit_cfg_q);
  assign limit    = (cfg_ext == '0) ? LIM_W'(1) :
                    ((cfg_ext > LIM_W'(FRAMES)) ? LIM_W'(FRAMES) : cfg_ext);
  assign fill_ext = LIM_W'(filled_q);
  assign has_free = (fill_ext < limit);
  assign fill_m1  = filled_q - FILL_W'(1);
  assign last_idx = fill_m1[IDX_W-1:0];

  // handshakes
  assign page_in.ready = (state_q == ST_IDLE);
  assign in_beat       = page_in.valid && page_in.ready;
  assign out_free      = !out_valid_q || res_out.ready;
  assign cfg_in.ready  = 1'b1;

  assign res_out.valid         = out_valid_q;
  assign res_out.outcome       = out_outcome_q;
  assign res_out.evicted_page  = out_evict_q;
  assign res_out.request_count = out_req_q;
  assign res_out.fault_count   = out_fault_q;

  // ram access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = page_q;
    ram_raddr = '0;
    unique case (state_q)
      ST_IDLE: begin
        ram_raddr = '0;
      end
      ST_SCAN: begin
        ram_raddr = idx_q + IDX_W'(1);
      end
      ST_MISS: begin
        if (has_free) begin
          ram_we    = 1'b1;
          ram_waddr = filled_q[IDX_W-1:0];
        end else begin
          ram_raddr = IDX_W'(1);
        end
      end
      ST_SHIFT: begin
        ram_we = 1'b1;
        if (idx_q != last_idx) begin
          ram_wdata = ram_rdata;
          ram_raddr = idx_q + IDX_W'(2);
        end
      end
      ST_FINISH: begin
        ram_raddr = '0;
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  lpr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_frames (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // request sequencer, counts and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      page_q        <= '0;
      first_q       <= '0;
      evict_q       <= '0;
      idx_q         <= '0;
      filled_q      <= '0;
      req_q         <= '0;
      fault_q       <= '0;
      limit_cfg_q   <= lpr_pkg::LIMIT_RESET;
      outcome_q     <= lpr_pkg::OUT_ZERO;
      out_valid_q   <= 1'b0;
      out_outcome_q <= '0;
      out_evict_q   <= '0;
      out_req_q     <= '0;
      out_fault_q   <= '0;
    end else begin
      if (cfg_in.valid && cfg_in.ready) begin
        limit_cfg_q <= cfg_in.frames_in_use;
      end
      // result beat taken; in finish the output register is reloaded below
      if (out_valid_q && res_out.ready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            page_q <= page_in_masked;
            if (page_in_masked == '0) begin
              outcome_q <= lpr_pkg::OUT_ZERO;
              evict_q   <= '0;
              state_q   <= ST_FINISH;
            end else begin
              if (req_q != lpr_pkg::COUNT_MAX) begin
                req_q <= req_q + CNT_W'(1);
              end
              idx_q <= '0;
              state_q <= (filled_q == '0) ? ST_MISS : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // compare the slot read last cycle
          if (idx_q == '0) begin
            first_q <= ram_rdata;
          end
          if (ram_rdata == page_q) begin
            outcome_q <= lpr_pkg::OUT_HIT;
            evict_q   <= '0;
            state_q   <= ST_SHIFT;
          end else if (idx_q == last_idx) begin
            state_q <= ST_MISS;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        ST_MISS: begin
          if (fault_q != lpr_pkg::COUNT_MAX) begin
            fault_q <= fault_q + CNT_W'(1);
          end
          if (has_free) begin
            filled_q  <= filled_q + FILL_W'(1);
            outcome_q <= lpr_pkg::OUT_FILL;
            evict_q   <= '0;
            state_q   <= ST_FINISH;
          end else begin
            outcome_q <= lpr_pkg::OUT_EVICT;
            evict_q   <= first_q;
            idx_q     <= '0;
            state_q   <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          // move newer slots down, then place the page as most recent
          if (idx_q == last_idx) begin
            state_q <= ST_FINISH;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_outcome_q <= outcome_q;
            out_evict_q   <= evict_wide[lpr_pkg::PAGE_FIELD_W-1:0];
            out_req_q     <= req_q;
            out_fault_q   <= fault_q;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/lpr_checker.sv -----
// port-level checks for the lru page replacement block, bound to the top level
`timescale 1ns / 1ps

module lpr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        out_outcome,
  input logic [lpr_pkg::PAGE_FIELD_W-1:0]  out_evicted,
  input logic [lpr_pkg::COUNT_W-1:0]       out_requests,
  input logic [lpr_pkg::COUNT_W-1:0]       out_faults
);

  // a stalled result beat holds its outcome, evicted page and request count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_outcome)
                                   && $stable(out_evicted) && $stable(out_requests)))
    else $error("result beat changed while stalled");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in work");

  // faults never outnumber requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_faults <= out_requests))
    else $error("fault count above request count");

  // only an eviction reports an evicted page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && (out_outcome != lpr_pkg::OUT_EVICT)) |-> (out_evicted == '0))
    else $error("evicted page set without eviction");

  // no result straight out of reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (page_in.valid),
  .in_ready     (page_in.ready),
  .out_valid    (res_out.valid),
  .out_ready    (res_out.ready),
  .out_outcome  (res_out.outcome),
  .out_evicted  (res_out.evicted_page),
  .out_requests (res_out.request_count),
  .out_faults   (res_out.fault_count)
);
